// ----- hdl/integer_to_ascii_formatter_core_defines.svh -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_defines
// assertion macros shared by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ITOA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ITOA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);
`else
`define ITOA_ASSERT_IMP(label, ante, cons, msg)
`define ITOA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// shared widths, codes and types of the integer to ascii formatter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int ValueWidth = 32;
   localparam int DigitCount = 10;
   localparam int HexDigits  = ValueWidth / 4;
   localparam int BcdWidth   = DigitCount * 4;
   localparam int IdxWidth   = $clog2(DigitCount);
   localparam int StepWidth  = $clog2(ValueWidth);
   localparam int KindWidth  = 2;
   localparam int WidthBits  = 4;
   localparam int CharWidth  = 8;

   localparam logic [KindWidth-1:0] KIND_SDEC  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_HEX   = 2'd1;
   localparam logic [KindWidth-1:0] KIND_FIXED = 2'd2;

   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_ALPHA = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2d;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_SKIP = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [ValueWidth-1:0] operand;
   } bcd_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_status_type;

   function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d);
      logic [CharWidth-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + CharWidth'(d);
      end else begin
         c = CHAR_ALPHA + CharWidth'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

// ----- hdl/itoa_if.sv -----
// ----------------------------------------------------------------------------
// itoa_if
// valid/ready channels for request and response items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface itoa_req_if
   import itoa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [KindWidth-1:0]  kind;
   logic [ValueWidth-1:0] value;
   logic [WidthBits-1:0]  width;

   modport source (output valid, kind, value, width, input ready);
   modport sink   (input valid, kind, value, width, output ready);
endinterface

interface itoa_rsp_if
   import itoa_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

// ----- hdl/itoa_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// itoa_bcd_unit
// shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_bcd_unit
   import itoa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  bcd_ctl_type         ctl,
   output bcd_status_type      status,
   output logic [BcdWidth-1:0] bcd
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [ValueWidth-1:0] shift_ff, shift_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [BcdWidth-1:0]   adj;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = ctl.operand;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bcd_in   = {adj[BcdWidth-2:0], shift_ff[ValueWidth-1]};
         shift_in = {shift_ff[ValueWidth-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == StepWidth'(ValueWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

// ----- hdl/integer_to_ascii_formatter_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// formats a 32-bit number as signed decimal, hex or fixed-width decimal text
// ----------------------------------------------------------------------------
//  port      dir   item fields             handshake
//  req_chan  in    kind, value, width      valid/ready
//  rsp_chan  out   char_code, last         valid/ready
//
//  signed decimal, n digits: accept, bcd shift, capture, minus if negative,
//  skip of leading zeros, n chars at one per cycle while rsp_chan takes them
//  fixed width w: accept, bcd shift, capture, w chars with leading zeros
//  hex, n digits: accept, skip of leading zeros, n chars; width zero
//  or unused kind: accept only; a stalled rsp_chan holds the sequencer per char
//  req_chan.ready only while idle; synchronous reset clears the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_core_defines.svh"

module integer_to_ascii_formatter_core
   import itoa_pkg::*;
(
   input logic          clock,
   input logic          reset,
   itoa_req_if.sink     req_chan,
   itoa_rsp_if.source   rsp_chan
);

   state_type            state_ff, state_in;
   logic [KindWidth-1:0] kind_ff, kind_in;
   logic                 neg_ff, neg_in;
   logic [IdxWidth-1:0]  idx_ff, idx_in;
   logic [BcdWidth-1:0]  digit_ff, digit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0] char_ff, char_in;
   logic                 last_ff, last_in;

   bcd_ctl_type          bcd_ctl;
   bcd_status_type       bcd_status;
   logic [BcdWidth-1:0]  bcd_digits;

   logic                 accept;
   logic                 load_ok;
   logic                 rsp_load;
   logic                 req_neg;
   logic [WidthBits-1:0] width_clip;
   logic [3:0]           cur_digit;

   itoa_bcd_unit u_bcd (
      .clock  (clock),
      .reset  (reset),
      .ctl    (bcd_ctl),
      .status (bcd_status),
      .bcd    (bcd_digits)
   );

   assign accept    = req_chan.valid && req_chan.ready;
   assign load_ok   = !rsp_valid_ff || rsp_chan.ready;
   assign req_neg   = (req_chan.kind == KIND_SDEC) && req_chan.value[ValueWidth-1];
   assign cur_digit = digit_ff[idx_ff*4 +: 4];

   always_comb begin
      if (req_chan.width > WidthBits'(DigitCount)) begin
         width_clip = WidthBits'(DigitCount);
      end else begin
         width_clip = req_chan.width;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      digit_in     = digit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_load     = 1'b0;
      bcd_ctl.start   = 1'b0;
      bcd_ctl.operand = req_neg ? (~req_chan.value + 1'b1) : req_chan.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_chan.kind;
               neg_in  = req_neg;
               case (req_chan.kind)
                  KIND_SDEC: begin
                     idx_in        = IdxWidth'(DigitCount - 1);
                     bcd_ctl.start = 1'b1;
                     state_in      = ST_CONV;
                  end
                  KIND_HEX: begin
                     idx_in   = IdxWidth'(HexDigits - 1);
                     digit_in = BcdWidth'(req_chan.value);
                     state_in = ST_SKIP;
                  end
                  KIND_FIXED: begin
                     if (width_clip != '0) begin
                        idx_in        = IdxWidth'(width_clip - 1'b1);
                        bcd_ctl.start = 1'b1;
                        state_in      = ST_CONV;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_status.done) begin
               digit_in = bcd_digits;
               if (kind_ff == KIND_FIXED) begin
                  state_in = ST_EMIT;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SIGN: begin
            if (load_ok) begin
               rsp_load = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               rsp_load = 1'b1;
               char_in  = digit_char(cur_digit);
               last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
      digit_ff <= digit_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last      = last_ff;

   `ITOA_ASSERT_IMP(a_done_in_conv, bcd_status.done, state_ff == ST_CONV, "bcd done outside conversion")
   `ITOA_ASSERT_IMP(a_sign_sdec, state_ff == ST_SIGN, kind_ff == KIND_SDEC && neg_ff, "sign state without negative signed item")
   `ITOA_ASSERT_IMP(a_dec_digit, state_ff == ST_EMIT && kind_ff != KIND_HEX, cur_digit < 4'd10, "decimal digit out of range")
   `ITOA_ASSERT_NXT(a_last_idle, rsp_load && last_in, state_ff == ST_IDLE && rsp_chan.last, "final char not followed by idle")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for integer_to_ascii_formatter_core: directed request
// items and then random bursts are driven, and every response char is checked
// in order against chars predicted per request, while the response side stalls
// at random and once holds off long enough to back up the request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import itoa_pkg::*;

   localparam int MaxDecDigits = 10;
   localparam int MaxHexDigits = 8;
   localparam int RandomItems  = 250;
   localparam int HoldOffCycles = 300;
   localparam int HoldOffAfter = 150;
   localparam int DrainCycles  = 100;
   localparam int IdleLimit    = 2000;
   localparam int MaxReports   = 20;

   localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 last;
   } text_char_type;

   class text_checker;
      text_char_type pending_chars[$];
      int            errors;
      int            checked;

      function new();
         errors  = 0;
         checked = 0;
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      // chars of one request, most significant first
      function void format_value(input logic [KindWidth-1:0] kind,
                                 input logic [ValueWidth-1:0] value,
                                 input logic [WidthBits-1:0] width);
         logic [CharWidth-1:0] digits[$];
         logic [CharWidth-1:0] line[$];
         logic [ValueWidth-1:0] mag;
         logic [3:0] nibble;
         int count;
         text_char_type ch;
         mag = value;
         case (kind)
            KIND_SDEC: begin
               if (value[ValueWidth-1]) begin
                  line.push_back(CHAR_MINUS);
                  mag = ~value + 1'b1;
               end
               do begin
                  digits.push_back(CHAR_ZERO + CharWidth'(mag % 10));
                  mag = mag / 10;
               end while (mag != 0 && digits.size() < MaxDecDigits);
            end
            KIND_HEX: begin
               do begin
                  nibble = mag[3:0];
                  digits.push_back(nibble < 4'd10 ? CHAR_ZERO + CharWidth'(nibble)
                                                  : CHAR_ALPHA + CharWidth'(nibble - 4'd10));
                  mag = mag >> 4;
               end while (mag != 0 && digits.size() < MaxHexDigits);
            end
            KIND_FIXED: begin
               count = (width > MaxDecDigits) ? MaxDecDigits : int'(width);
               repeat (count) begin
                  digits.push_back(CHAR_ZERO + CharWidth'(mag % 10));
                  mag = mag / 10;
               end
            end
            default: begin
            end
         endcase
         for (int i = digits.size() - 1; i >= 0; i--) begin
            line.push_back(digits[i]);
         end
         for (int i = 0; i < line.size(); i++) begin
            ch.char_code = line[i];
            ch.last      = (i == line.size() - 1);
            pending_chars.push_back(ch);
         end
      endfunction

      task report_mismatch(input string what);
         errors++;
         if (errors <= MaxReports) begin
            $display("testbench: mismatch at %0t: %s", $realtime, what);
         end
      endtask

      task check_char(input logic [CharWidth-1:0] char_code, input logic last);
         text_char_type want;
         checked++;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("char %h last %b with nothing pending",
                                      char_code, last));
         end else begin
            want = pending_chars.pop_front();
            if (char_code !== want.char_code) begin
               report_mismatch($sformatf("char %h, predicted %h", char_code,
                                         want.char_code));
            end
            if (last !== want.last) begin
               report_mismatch($sformatf("last %b on char %h, predicted %b", last,
                                         want.char_code, want.last));
            end
         end
      endtask

      task check_drained();
         if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   itoa_req_if req_chan ();
   itoa_rsp_if rsp_chan ();

   integer_to_ascii_formatter_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   text_checker sb = new();
   int kind_counts[4];
   int counted_items;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            kind_counts[req_chan.kind]++;
            sb.format_value(req_chan.kind, req_chan.value, req_chan.width);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_char(rsp_chan.char_code, rsp_chan.last);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("testbench: no item moved for %0d cycles", IdleLimit);
      $display("testbench: FAIL");
      $finish;
   end

   // response side: random stall patterns, one long hold-off
   initial begin
      int mode;
      int span;
      int phase;
      bit held;
      mode  = 0;
      span  = 0;
      phase = 0;
      held  = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sb.checked >= HoldOffAfter) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(4, 40);
            end
            span--;
            phase++;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [KindWidth-1:0] kind,
                            input logic [ValueWidth-1:0] value,
                            input logic [WidthBits-1:0] width);
      req_chan.valid <= 1'b1;
      req_chan.kind  <= kind;
      req_chan.value <= value;
      req_chan.width <= width;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic rest_sender(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         req_chan.kind  <= KindWidth'($urandom_range(0, 3));
         req_chan.value <= $urandom;
         req_chan.width <= WidthBits'($urandom_range(0, 15));
         repeat (cycles) @(negedge clock);
      end
   endtask

   initial begin
      logic [KindWidth-1:0]  k;
      logic [ValueWidth-1:0] v;
      logic [WidthBits-1:0]  w;
      logic [ValueWidth-1:0] p;
      int burst;
      int pick;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind  = KIND_SDEC;
      req_chan.value = '0;
      req_chan.width = '0;
      counted_items  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // signed decimal extremes
      send_item(KIND_SDEC, 32'd0, 4'd0);
      send_item(KIND_SDEC, 32'd1, 4'd15);
      send_item(KIND_SDEC, 32'hFFFF_FFFF, 4'd5);
      send_item(KIND_SDEC, 32'h7FFF_FFFF, 4'd10);
      send_item(KIND_SDEC, 32'h8000_0000, 4'd0);
      send_item(KIND_SDEC, 32'd10, 4'd1);
      send_item(KIND_SDEC, 32'd1000000000, 4'd3);
      send_item(KIND_SDEC, 32'hC465_3600, 4'd7);
      // hex
      send_item(KIND_HEX, 32'd0, 4'd2);
      send_item(KIND_HEX, 32'hFFFF_FFFF, 4'd0);
      send_item(KIND_HEX, 32'h0000_000F, 4'd15);
      send_item(KIND_HEX, 32'hABCD_EF09, 4'd8);
      send_item(KIND_HEX, 32'h1000_0000, 4'd4);
      // fixed width, including zero width and saturation above ten
      send_item(KIND_FIXED, 32'd123, 4'd0);
      send_item(KIND_FIXED, 32'hFFFF_FFFF, 4'd1);
      send_item(KIND_FIXED, 32'hFFFF_FFFF, 4'd10);
      send_item(KIND_FIXED, 32'hFFFF_FFFF, 4'd15);
      send_item(KIND_FIXED, 32'd42, 4'd11);
      send_item(KIND_FIXED, 32'd7, 4'd5);
      send_item(KIND_FIXED, 32'd0, 4'd10);
      // unused kind is ignored
      send_item(KIND_UNUSED, 32'h1234_5678, 4'd6);
      send_item(KIND_SDEC, 32'd9, 4'd9);
      rest_sender(30);

      while (counted_items < RandomItems) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               k = KIND_UNUSED;
            end else if (pick < 35) begin
               k = KIND_SDEC;
            end else if (pick < 65) begin
               k = KIND_HEX;
            end else begin
               k = KIND_FIXED;
            end
            case ($urandom_range(0, 5))
               0: v = $urandom;
               1: v = $urandom_range(0, 99);
               2: v = 32'd0 - $urandom_range(1, 999);
               3: begin
                  p = 1;
                  repeat ($urandom_range(0, 9)) p = p * 10;
                  v = p + $urandom_range(0, 2) - 1;
                  if ($urandom_range(0, 1)) begin
                     v = 32'd0 - v;
                  end
               end
               4: begin
                  case ($urandom_range(0, 3))
                     0: v = 32'd0;
                     1: v = 32'h7FFF_FFFF;
                     2: v = 32'h8000_0000;
                     default: v = 32'hFFFF_FFFF;
                  endcase
               end
               default: v = $urandom >> $urandom_range(0, 31);
            endcase
            if ($urandom_range(0, 3) == 0) begin
               w = WidthBits'($urandom_range(0, 15));
            end else begin
               w = WidthBits'($urandom_range(1, 10));
            end
            send_item(k, v, w);
            if (k != KIND_UNUSED) begin
               counted_items++;
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            rest_sender(0);
         end else begin
            rest_sender($urandom_range(1, 20));
         end
      end
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      sb.check_drained();

      $display("testbench: %0d requests (%0d signed decimal, %0d hex, %0d fixed width, %0d ignored)",
               kind_counts[0] + kind_counts[1] + kind_counts[2] + kind_counts[3],
               kind_counts[KIND_SDEC], kind_counts[KIND_HEX], kind_counts[KIND_FIXED],
               kind_counts[KIND_UNUSED]);
      $display("testbench: %0d chars checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
